// ----- sv/fqpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the FIFO queue with peek and reverse.
// No dependencies; imported by the queue core.
package fqpr_pkg;

	typedef enum logic [2:0] {
		MODE_ENQ  = 3'd0,
		MODE_DEQ  = 3'd1,
		MODE_PEEK = 3'd2,
		MODE_CLR  = 3'd3,
		MODE_REV  = 3'd4
	} mode_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_EMPTY  = 2'd1;
	localparam status_t ST_BOUNDS = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

	localparam int unsigned FIELD_W = 32;
	localparam int unsigned INDEX_W = 5;
	localparam int unsigned COUNT_W = 5;

endpackage

// ----- sv/fqpr_ram.sv -----
`timescale 1ns / 1ps
// Single-port synchronous entry store with registered read data.
// Standalone; instantiated by the queue core.
module fqpr_ram #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     addr,
	input  logic [DATA_WIDTH-1:0]        wdata,
	output logic [DATA_WIDTH-1:0]        rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// Read data holds its value until the next read, which the core relies on
	// while a result is stalled.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- sv/fifo_queue_with_peek_reverse_core.sv -----
`timescale 1ns / 1ps
// Top level of the FIFO queue with peek and reverse: command decode, pointers and result path.
// Depends on fqpr_pkg and fqpr_ram.
//
// The block takes one command item per cycle and returns exactly one result item for each,
// in order, via the pipeline register and the output register. Pointer and count updates happen
// in the cycle a command is accepted, so a following command already sees them. The entries live in a
// single-port RAM: an enqueue writes one entry and a peek reads one, and since a peek only reads
// occupied entries while an enqueue only writes a free one, the two never collide. The RAM read
// data lines up with a one-stage pipeline register and then lands in the output register, and
// input is taken whenever that stage can move on, so the sustained rate is one item per cycle
// as long as the result side keeps taking items. There is no clearing pass after reset.
module fifo_queue_with_peek_reverse_core #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value [31:0], index [36:32], zero [39:37]
	input  logic [2:0]  s_tuser,   // mode [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // data [31:0], status [33:32], count [38:34], empty_res [39]
);

	import fqpr_pkg::*;

	localparam int unsigned AW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned SW   = CW + 1;
	localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;

	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rev_q, rev_d;

	logic                  valid_s1;
	status_t               status_s1;
	logic [COUNT_W-1:0]    count_s1;
	logic                  empty_s1;
	logic                  peek_s1;

	logic                  out_valid_q;
	logic [FIELD_W-1:0]    out_data_q;
	status_t               out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_empty_q;

	mode_t                 cmd_mode;
	logic [FIELD_W-1:0]    cmd_value;
	logic [INDEX_W-1:0]    cmd_index;
	logic                  acc, out_free, s1_move;

	status_t               status_d;
	logic                  peek_ok;
	logic                  ram_en, ram_we;
	logic [AW-1:0]         ram_addr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic [CMPW-1:0]       idx_w, cnt_w;
	logic [SW-1:0]         peek_sum, enq_sum;
	logic [AW-1:0]         peek_addr, enq_addr, head_dec, head_inc;
	logic                  full, idx_bad;

	assign cmd_mode  = mode_t'(s_tuser);
	assign cmd_value = s_tdata[31:0];
	assign cmd_index = s_tdata[36:32];

	assign out_free = !out_valid_q || m_tready;
	assign s1_move  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign acc      = s_tvalid && s_tready;

	assign full    = (cnt_q == CW'(DEPTH));
	assign idx_w   = CMPW'(cmd_index);
	assign cnt_w   = CMPW'(cnt_q);
	assign idx_bad = (cnt_q == '0) || (idx_w == '0) || (idx_w > cnt_w);

	// Position pos from the front, counted from 1, maps to head + pos - 1 normally,
	// and to head + count - pos when reversed; both stay below twice the depth.
	always_comb begin
		if (rev_q) begin
			peek_sum = SW'(head_q) + SW'(cnt_q) - SW'(idx_w);
		end else begin
			peek_sum = SW'(head_q) + SW'(idx_w) - SW'(1);
		end
		enq_sum = SW'(head_q) + SW'(cnt_q);
	end

	assign peek_addr = (peek_sum >= SW'(DEPTH)) ? AW'(peek_sum - SW'(DEPTH)) : AW'(peek_sum);
	assign enq_addr  = (enq_sum >= SW'(DEPTH)) ? AW'(enq_sum - SW'(DEPTH)) : AW'(enq_sum);
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		head_d   = head_q;
		cnt_d    = cnt_q;
		rev_d    = rev_q;
		status_d = ST_OK;
		peek_ok  = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = peek_addr;
		if (acc) begin
			unique case (cmd_mode)
				MODE_ENQ: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						ram_en = 1'b1;
						ram_we = 1'b1;
						cnt_d  = cnt_q + CW'(1);
						if (rev_q) begin
							head_d   = head_dec;
							ram_addr = head_dec;
						end else begin
							ram_addr = enq_addr;
						end
					end
				end
				MODE_DEQ: begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						cnt_d = cnt_q - CW'(1);
						if (!rev_q) begin
							head_d = head_inc;
						end
					end
				end
				MODE_PEEK: begin
					if (idx_bad) begin
						status_d = ST_BOUNDS;
					end else begin
						peek_ok = 1'b1;
						ram_en  = 1'b1;
					end
				end
				MODE_CLR: begin
					head_d = '0;
					cnt_d  = '0;
					rev_d  = 1'b0;
				end
				MODE_REV: begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						rev_d = !rev_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	fqpr_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (DATA_WIDTH'(cmd_value)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			rev_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= head_d;
			cnt_q  <= cnt_d;
			rev_q  <= rev_d;
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
			count_s1  <= COUNT_W'(cnt_d);
			empty_s1  <= (cnt_d == '0);
			peek_s1   <= peek_ok;
		end
		if (s1_move) begin
			out_data_q   <= peek_s1 ? FIELD_W'(ram_rdata) : '0;
			out_status_q <= status_s1;
			out_count_q  <= count_s1;
			out_empty_q  <= empty_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_empty_q, out_count_q, out_status_q, out_data_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < AW'(DEPTH - 1) || head_q == AW'(DEPTH - 1))
		else $error("head pointer out of range");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd_mode == MODE_CLR |=> cnt_q == '0 && head_q == '0 && !rev_q)
		else $error("clear did not restore pointers");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd_mode == MODE_ENQ && !full |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("enqueue did not advance count");

	a_stall_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |-> !ram_en)
		else $error("RAM accessed while pending read data is stalled");

endmodule
